/* rtl/core/tlbol_pkg.sv */
// shared types and codes for the oldest-load tlb
`default_nettype none

package tlbol_pkg;

    localparam int unsigned TAG_W   = 16;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned CMD_W   = 3;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOOKUP   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INV_PID  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INV_PAGE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

    // commit commands broadcast to the cells
    localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INV_PID  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INV_PAGE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    // partial search result handed from cell to cell
    typedef struct packed {
        logic               hit;
        logic [TAG_W-1:0]   hit_frame;
        logic               free_found;
        logic               min_valid;
        logic [STAMP_W-1:0] min_stamp;
        logic               min_dirty;
        logic [TAG_W-1:0]   min_pid;
        logic [TAG_W-1:0]   min_page;
        logic [TAG_W-1:0]   min_frame;
    } carry_t;

    // update applied to the cells at the end of a transaction
    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [TAG_W-1:0]   pid;
        logic [TAG_W-1:0]   page;
        logic [TAG_W-1:0]   frame;
        logic               dirty;
        logic [STAMP_W-1:0] stamp;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/tlb_with_oldest_load_replacement.sv */
// top level: fully associative tlb with oldest-load replacement
// flow: an accepted transaction walks the search chain of cells one entry per cycle, then the
//   commit state applies the update; the result is registered and shown on the ports with done high,
//   and busy drops while the result is out, so a new transaction can be accepted only from then on
// reset: all entries invalid, load counter zero, entries_in_use 16; no clearing pass
`default_nettype none

module tlb_with_oldest_load_replacement #(
    parameter int unsigned TLB_ENTRIES = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    // command channel
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  kind,
    input  wire  [15:0] pid,
    input  wire  [15:0] page_number,
    input  wire  [15:0] frame_number,
    input  wire         is_write,
    // result channel
    output logic        done,
    output logic        hit,
    output logic [15:0] hit_frame,
    output logic        writeback,
    output logic [15:0] wb_pid,
    output logic [15:0] wb_page,
    output logic [15:0] wb_frame,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [IDX_W-1:0]                scan_cnt_reg, scan_cnt_next;
    logic [4:0]                      entries_in_use_reg, entries_in_use_next;
    logic [tlbol_pkg::STAMP_W-1:0]   load_counter_reg, load_counter_next;

    logic [tlbol_pkg::KIND_W-1:0]    req_kind_reg;
    logic [15:0]                     req_pid_reg;
    logic [15:0]                     req_page_reg;
    logic [15:0]                     req_frame_reg;
    logic                            req_write_reg;

    logic                            done_reg, done_next;
    logic                            hit_reg, hit_next;
    logic [15:0]                     hit_frame_reg, hit_frame_next;
    logic                            wb_reg, wb_next;
    logic [15:0]                     wb_pid_reg, wb_pid_next;
    logic [15:0]                     wb_page_reg, wb_page_next;
    logic [15:0]                     wb_frame_reg, wb_frame_next;

    tlbol_pkg::carry_t               chain [TLB_ENTRIES+1];
    logic [IDX_W-1:0]                free_chain [TLB_ENTRIES+1];
    logic [IDX_W-1:0]                min_chain [TLB_ENTRIES+1];
    tlbol_pkg::carry_t               last;
    tlbol_pkg::cmd_t                 cmd;
    logic [IDX_W-1:0]                cmd_idx;
    logic                            accept;
    logic                            cfg_write;
    logic                            can_load;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {27'd0, entries_in_use_reg} : 32'd0;

    assign chain[0]      = '0;
    assign free_chain[0] = '0;
    assign min_chain[0]  = '0;
    assign last          = chain[TLB_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < TLB_ENTRIES; g++)
        begin : g_cell
            logic active;
            // slots 0 .. entries_in_use-1 take part in lookups and inserts
            assign active = ({27'd0, entries_in_use_reg} > 32'(g));

            tlbol_cell #(
                .IDX_W      (IDX_W),
                .CELL_INDEX (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .active       (active),
                .req_pid      (req_pid_reg),
                .req_page     (req_page_reg),
                .carry_in     (chain[g]),
                .free_idx_in  (free_chain[g]),
                .min_idx_in   (min_chain[g]),
                .carry_out    (chain[g+1]),
                .free_idx_out (free_chain[g+1]),
                .min_idx_out  (min_chain[g+1]),
                .cmd          (cmd),
                .cmd_idx      (cmd_idx)
            );
        end
    endgenerate

    assign can_load = last.free_found || last.min_valid;
    assign cmd_idx  = last.free_found ? free_chain[TLB_ENTRIES] : min_chain[TLB_ENTRIES];

    // commit command, only in the final cycle of a transaction
    always_comb
    begin
        cmd.pid   = req_pid_reg;
        cmd.page  = req_page_reg;
        cmd.frame = req_frame_reg;
        cmd.dirty = req_write_reg;
        cmd.stamp = load_counter_reg;
        cmd.op    = tlbol_pkg::CMD_NONE;
        if (state_reg == ST_DONE)
        begin
            unique case (req_kind_reg)
                tlbol_pkg::KIND_INSERT:
                    cmd.op = can_load ? tlbol_pkg::CMD_LOAD : tlbol_pkg::CMD_NONE;
                tlbol_pkg::KIND_INV_PID:  cmd.op = tlbol_pkg::CMD_INV_PID;
                tlbol_pkg::KIND_INV_PAGE: cmd.op = tlbol_pkg::CMD_INV_PAGE;
                tlbol_pkg::KIND_CLEAR:    cmd.op = tlbol_pkg::CMD_CLEAR;
                default:                  cmd.op = tlbol_pkg::CMD_NONE;
            endcase
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        scan_cnt_next       = scan_cnt_reg;
        load_counter_next   = load_counter_reg;
        entries_in_use_next = cfg_write ? pwdata[4:0] : entries_in_use_reg;
        done_next           = 1'b0;
        hit_next            = 1'b0;
        hit_frame_next      = '0;
        wb_next             = 1'b0;
        wb_pid_next         = '0;
        wb_page_next        = '0;
        wb_frame_next       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (req_kind_reg == tlbol_pkg::KIND_LOOKUP)
                begin
                    hit_next       = last.hit;
                    hit_frame_next = last.hit_frame;
                end
                if ((req_kind_reg == tlbol_pkg::KIND_INSERT) && can_load)
                begin
                    load_counter_next = load_counter_reg + 1'b1;
                    // replacement of a dirty entry needs a write-back
                    if (!last.free_found && last.min_dirty)
                    begin
                        wb_next       = 1'b1;
                        wb_pid_next   = last.min_pid;
                        wb_page_next  = last.min_page;
                        wb_frame_next = last.min_frame;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            scan_cnt_reg       <= '0;
            entries_in_use_reg <= 5'd16;
            load_counter_reg   <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            scan_cnt_reg       <= scan_cnt_next;
            entries_in_use_reg <= entries_in_use_next;
            load_counter_reg   <= load_counter_next;
            done_reg           <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_kind_reg  <= kind;
            req_pid_reg   <= pid;
            req_page_reg  <= page_number;
            req_frame_reg <= frame_number;
            req_write_reg <= is_write;
        end
        hit_reg       <= hit_next;
        hit_frame_reg <= hit_frame_next;
        wb_reg        <= wb_next;
        wb_pid_reg    <= wb_pid_next;
        wb_page_reg   <= wb_page_next;
        wb_frame_reg  <= wb_frame_next;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign hit_frame = hit_frame_reg;
    assign writeback = wb_reg;
    assign wb_pid    = wb_pid_reg;
    assign wb_page   = wb_page_reg;
    assign wb_frame  = wb_frame_reg;

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_DONE))
        else $error("result strobe without a commit cycle");

    a_hit_wb_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(hit_reg && wb_reg))
        else $error("hit and write-back in one result");

    a_counter_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(load_counter_reg) |->
            $past(state_reg == ST_DONE && req_kind_reg == tlbol_pkg::KIND_INSERT))
        else $error("load counter moved outside an insert commit");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg != ST_IDLE))
        else $error("scan left without a commit cycle");

endmodule

`default_nettype wire

/* rtl/core/tlbol_cell.sv */
// one tlb entry with its stage of the search chain
`default_nettype none

module tlbol_cell #(
    parameter int unsigned IDX_W      = 4,
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            active,
    input  wire [tlbol_pkg::TAG_W-1:0]     req_pid,
    input  wire [tlbol_pkg::TAG_W-1:0]     req_page,
    input  wire tlbol_pkg::carry_t         carry_in,
    input  wire [IDX_W-1:0]                free_idx_in,
    input  wire [IDX_W-1:0]                min_idx_in,
    output tlbol_pkg::carry_t              carry_out,
    output logic [IDX_W-1:0]               free_idx_out,
    output logic [IDX_W-1:0]               min_idx_out,
    input  wire tlbol_pkg::cmd_t           cmd,
    input  wire [IDX_W-1:0]                cmd_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic                            valid_reg, valid_next;
    logic                            dirty_reg, dirty_next;
    logic [tlbol_pkg::TAG_W-1:0]     pid_reg, pid_next;
    logic [tlbol_pkg::TAG_W-1:0]     page_reg, page_next;
    logic [tlbol_pkg::TAG_W-1:0]     frame_reg, frame_next;
    logic [tlbol_pkg::STAMP_W-1:0]   stamp_reg, stamp_next;

    tlbol_pkg::carry_t               carry_reg, carry_next;
    logic [IDX_W-1:0]                free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]                min_idx_reg, min_idx_next;

    logic match;
    logic pid_match;

    assign pid_match = valid_reg && (pid_reg == req_pid);
    assign match     = pid_match && (page_reg == req_page);

    // search stage
    always_comb
    begin
        carry_next    = carry_in;
        free_idx_next = free_idx_in;
        min_idx_next  = min_idx_in;
        if (active)
        begin
            if (!carry_in.hit && match)
            begin
                carry_next.hit       = 1'b1;
                carry_next.hit_frame = frame_reg;
            end
            if (!carry_in.free_found && !valid_reg)
            begin
                carry_next.free_found = 1'b1;
                free_idx_next         = MY_IDX;
            end
            // strict compare keeps the lowest slot on equal stamps
            if (valid_reg && (!carry_in.min_valid || (stamp_reg < carry_in.min_stamp)))
            begin
                carry_next.min_valid = 1'b1;
                carry_next.min_stamp = stamp_reg;
                carry_next.min_dirty = dirty_reg;
                carry_next.min_pid   = pid_reg;
                carry_next.min_page  = page_reg;
                carry_next.min_frame = frame_reg;
                min_idx_next         = MY_IDX;
            end
        end
    end

    // entry update
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        pid_next   = pid_reg;
        page_next  = page_reg;
        frame_next = frame_reg;
        stamp_next = stamp_reg;
        unique case (cmd.op) inside
            tlbol_pkg::CMD_LOAD:
            begin
                if (cmd_idx == MY_IDX)
                begin
                    valid_next = 1'b1;
                    dirty_next = cmd.dirty;
                    pid_next   = cmd.pid;
                    page_next  = cmd.page;
                    frame_next = cmd.frame;
                    stamp_next = cmd.stamp;
                end
            end
            tlbol_pkg::CMD_INV_PID,
            tlbol_pkg::CMD_INV_PAGE,
            tlbol_pkg::CMD_CLEAR:
            begin
                if ((cmd.op == tlbol_pkg::CMD_CLEAR) ||
                    (valid_reg && (pid_reg == cmd.pid) &&
                     ((cmd.op == tlbol_pkg::CMD_INV_PID) || (page_reg == cmd.page))))
                begin
                    valid_next = 1'b0;
                    dirty_next = 1'b0;
                    pid_next   = '0;
                    page_next  = '0;
                    frame_next = '0;
                    stamp_next = '0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dirty_reg    <= dirty_next;
        pid_reg      <= pid_next;
        page_reg     <= page_next;
        frame_reg    <= frame_next;
        stamp_reg    <= stamp_next;
        carry_reg    <= carry_next;
        free_idx_reg <= free_idx_next;
        min_idx_reg  <= min_idx_next;
    end

    assign carry_out    = carry_reg;
    assign free_idx_out = free_idx_reg;
    assign min_idx_out  = min_idx_reg;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// testbench for the oldest-load tlb: shadow translation table, scoreboard and command driver
module tb;

    localparam int TLB_SLOTS = 16;
    localparam logic [2:0] KIND_FIRST_UNUSED = tlbol_pkg::KIND_CLEAR + 3'd1;
    localparam logic [2:0] KIND_MID_UNUSED   = tlbol_pkg::KIND_CLEAR + 3'd2;
    localparam logic [2:0] KIND_LAST_UNUSED  = 3'd7;
    localparam logic [2:0] ADDR_ENTRIES_IN_USE = 3'd0;
    localparam int ITEMS_PER_PHASE = 172;

    typedef struct packed {
        logic        hit;
        logic [15:0] hit_frame;
        logic        writeback;
        logic [15:0] wb_pid;
        logic [15:0] wb_page;
        logic [15:0] wb_frame;
    } translation_t;

    class tlb_scoreboard;
        bit          slot_valid [TLB_SLOTS];
        bit [15:0]   slot_pid   [TLB_SLOTS];
        bit [15:0]   slot_page  [TLB_SLOTS];
        bit [15:0]   slot_frame [TLB_SLOTS];
        bit          slot_dirty [TLB_SLOTS];
        bit [31:0]   slot_stamp [TLB_SLOTS];
        bit [31:0]   load_count;
        bit [4:0]    active_limit;
        translation_t expected_translations[$];
        int fail_count;
        int checked;
        int hits;
        int writebacks;

        function new();
            int i;
            for (i = 0; i < TLB_SLOTS; i++)
                drop_slot(i);
            load_count = 0;
            active_limit = 5'd16;
            fail_count = 0;
            checked = 0;
            hits = 0;
            writebacks = 0;
        endfunction

        function void drop_slot(int i);
            slot_valid[i] = 0;
            slot_pid[i]   = '0;
            slot_page[i]  = '0;
            slot_frame[i] = '0;
            slot_dirty[i] = 0;
            slot_stamp[i] = '0;
        endfunction

        function int pending();
            return expected_translations.size();
        endfunction

        // work out the translation result of one accepted transaction
        function void apply_request(logic [2:0] op, logic [15:0] req_pid,
                                    logic [15:0] req_page, logic [15:0] req_frame,
                                    logic req_write);
            translation_t r;
            int n;
            int i;
            int slot;
            bit found;
            r = '0;
            n = (active_limit > TLB_SLOTS) ? TLB_SLOTS : int'(active_limit);
            case (op)
                tlbol_pkg::KIND_LOOKUP:
                begin
                    for (i = 0; i < n; i++)
                        if (!r.hit && slot_valid[i] && slot_pid[i] == req_pid
                            && slot_page[i] == req_page)
                        begin
                            r.hit = 1'b1;
                            r.hit_frame = slot_frame[i];
                        end
                end
                tlbol_pkg::KIND_INSERT:
                begin
                    if (n > 0)
                    begin
                        found = 0;
                        slot = 0;
                        for (i = 0; i < n; i++)
                            if (!found && !slot_valid[i])
                            begin
                                slot = i;
                                found = 1;
                            end
                        if (!found)
                        begin
                            // oldest stamp wins, lowest slot on a tie
                            for (i = 1; i < n; i++)
                                if (slot_stamp[i] < slot_stamp[slot])
                                    slot = i;
                            if (slot_dirty[slot])
                            begin
                                r.writeback = 1'b1;
                                r.wb_pid    = slot_pid[slot];
                                r.wb_page   = slot_page[slot];
                                r.wb_frame  = slot_frame[slot];
                            end
                        end
                        slot_valid[slot] = 1;
                        slot_pid[slot]   = req_pid;
                        slot_page[slot]  = req_page;
                        slot_frame[slot] = req_frame;
                        slot_dirty[slot] = req_write;
                        slot_stamp[slot] = load_count;
                        load_count = load_count + 32'd1;
                    end
                end
                tlbol_pkg::KIND_INV_PID:
                begin
                    for (i = 0; i < TLB_SLOTS; i++)
                        if (slot_valid[i] && slot_pid[i] == req_pid)
                            drop_slot(i);
                end
                tlbol_pkg::KIND_INV_PAGE:
                begin
                    for (i = 0; i < TLB_SLOTS; i++)
                        if (slot_valid[i] && slot_pid[i] == req_pid
                            && slot_page[i] == req_page)
                            drop_slot(i);
                end
                tlbol_pkg::KIND_CLEAR:
                begin
                    for (i = 0; i < TLB_SLOTS; i++)
                        drop_slot(i);
                end
                default: ;
            endcase
            expected_translations.push_back(r);
        endfunction

        function void check_result(translation_t got);
            translation_t want;
            if (expected_translations.size() == 0)
            begin
                $error("result with no transaction outstanding: %h", got);
                fail_count++;
                return;
            end
            want = expected_translations.pop_front();
            checked++;
            if (got.hit) hits++;
            if (got.writeback) writebacks++;
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %h, got %h", want.hit, got.hit);
                fail_count++;
            end
            if (got.hit_frame !== want.hit_frame)
            begin
                $error("hit_frame: expected %h, got %h", want.hit_frame, got.hit_frame);
                fail_count++;
            end
            if (got.writeback !== want.writeback)
            begin
                $error("writeback: expected %h, got %h", want.writeback, got.writeback);
                fail_count++;
            end
            if (got.wb_pid !== want.wb_pid)
            begin
                $error("wb_pid: expected %h, got %h", want.wb_pid, got.wb_pid);
                fail_count++;
            end
            if (got.wb_page !== want.wb_page)
            begin
                $error("wb_page: expected %h, got %h", want.wb_page, got.wb_page);
                fail_count++;
            end
            if (got.wb_frame !== want.wb_frame)
            begin
                $error("wb_frame: expected %h, got %h", want.wb_frame, got.wb_frame);
                fail_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [15:0] pid;
    logic [15:0] page_number;
    logic [15:0] frame_number;
    logic        is_write;
    logic        done;
    logic        hit;
    logic [15:0] hit_frame;
    logic        writeback;
    logic [15:0] wb_pid;
    logic [15:0] wb_page;
    logic [15:0] wb_frame;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tlb_scoreboard sb;
    int items_sent;
    int phases_run;
    logic [15:0] tag_pool [0:7] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                    16'h5A5A, 16'h7FFF, 16'h00FF, 16'h1234};
    logic [15:0] recent_pid  [0:7];
    logic [15:0] recent_page [0:7];
    int recent_wr;

    tlb_with_oldest_load_replacement #(.TLB_ENTRIES(TLB_SLOTS)) uut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .kind(kind), .pid(pid), .page_number(page_number),
        .frame_number(frame_number), .is_write(is_write),
        .done(done), .hit(hit), .hit_frame(hit_frame),
        .writeback(writeback), .wb_pid(wb_pid), .wb_page(wb_page), .wb_frame(wb_frame),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // results are checked before the transaction of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result('{hit, hit_frame, writeback, wb_pid, wb_page, wb_frame});
            if (start && !busy)
                sb.apply_request(kind, pid, page_number, frame_number, is_write);
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [15:0] p,
                                input logic [15:0] g, input logic [15:0] f, input logic w);
        start        <= 1'b1;
        kind         <= op;
        pid          <= p;
        page_number  <= g;
        frame_number <= f;
        is_write     <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic maybe_idle();
        bit quiet;
        quiet = (items_sent >= 450 && items_sent < 800);
        if (!quiet && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20))
                @(posedge clk);
        end
    endtask

    // write the register, then read it back in the next transfer
    task automatic program_entries(input logic [4:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENTRIES_IN_USE;
        pwdata  <= {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.active_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {27'd0, value})
        begin
            $error("entries_in_use: expected %h, got %h", {27'd0, value}, readback);
            sb.fail_count++;
        end
    endtask

    function automatic logic [15:0] pick_tag(input int pool_size);
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return tag_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    task automatic run_random_items(input int count, input bit pause_midway);
        int k;
        int r;
        int j;
        logic [2:0] op;
        logic [15:0] p;
        logic [15:0] g;
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
                op = tlbol_pkg::KIND_LOOKUP;
            else if (r < 83)
                op = tlbol_pkg::KIND_INSERT;
            else if (r < 88)
                op = tlbol_pkg::KIND_INV_PID;
            else if (r < 95)
                op = tlbol_pkg::KIND_INV_PAGE;
            else if (r < 97)
                op = tlbol_pkg::KIND_CLEAR;
            else
                op = 3'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
            // lookups and invalidates often aim at a recently loaded page
            if (op != tlbol_pkg::KIND_INSERT && $urandom_range(0, 1) == 1)
            begin
                j = $urandom_range(0, 7);
                p = recent_pid[j];
                g = recent_page[j];
            end
            else
            begin
                p = pick_tag(4);
                g = pick_tag(8);
            end
            send_request(op, p, g, 16'($urandom), 1'($urandom_range(0, 1)));
            if (op == tlbol_pkg::KIND_INSERT)
            begin
                recent_pid[recent_wr]  = p;
                recent_page[recent_wr] = g;
                recent_wr = (recent_wr + 1) % 8;
            end
            items_sent++;
            if (pause_midway && k == count / 2)
                wait_drained();
            else
                maybe_idle();
        end
    endtask

    initial
    begin
        int p;
        int phase_entries [0:8];
        phase_entries = '{16, 1, 5, 31, 0, 17, 8, 2, 16};
        sb = new();
        items_sent = 0;
        phases_run = 0;
        recent_wr = 0;
        for (p = 0; p < 8; p++)
        begin
            recent_pid[p]  = tag_pool[p % 4];
            recent_page[p] = tag_pool[p];
        end
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = tlbol_pkg::KIND_LOOKUP;
        pid          = '0;
        page_number  = '0;
        frame_number = '0;
        is_write     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = ADDR_ENTRIES_IN_USE;
        pwdata       = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: two slots make eviction and write-back quick to reach
        program_entries(5'd2);
        send_request(tlbol_pkg::KIND_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_request(tlbol_pkg::KIND_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_request(tlbol_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(tlbol_pkg::KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_request(tlbol_pkg::KIND_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
        send_request(tlbol_pkg::KIND_INSERT, 16'h0007, 16'h0007, 16'h0007, 1'b1);
        send_request(tlbol_pkg::KIND_INSERT, 16'h0008, 16'h0008, 16'h0008, 1'b0);
        send_request(tlbol_pkg::KIND_INSERT, 16'h0008, 16'h0008, 16'hAAAA, 1'b1);
        // duplicate copies of one page: lowest slot reports
        send_request(tlbol_pkg::KIND_LOOKUP, 16'h0008, 16'h0008, 16'h0000, 1'b0);
        send_request(tlbol_pkg::KIND_INV_PAGE, 16'h0008, 16'h0008, 16'h0000, 1'b0);
        send_request(tlbol_pkg::KIND_LOOKUP, 16'h0008, 16'h0008, 16'h0000, 1'b0);
        send_request(tlbol_pkg::KIND_INSERT, 16'h0001, 16'h0002, 16'h0003, 1'b1);
        send_request(tlbol_pkg::KIND_INSERT, 16'h0001, 16'h0004, 16'h0005, 1'b0);
        send_request(tlbol_pkg::KIND_INV_PID, 16'h0001, 16'h0000, 16'h0000, 1'b0);
        send_request(tlbol_pkg::KIND_LOOKUP, 16'h0001, 16'h0002, 16'h0000, 1'b0);
        send_request(KIND_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(KIND_MID_UNUSED, 16'h5A5A, 16'hA5A5, 16'h1234, 1'b1);
        send_request(KIND_LAST_UNUSED, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        send_request(tlbol_pkg::KIND_INSERT, 16'h0003, 16'h0003, 16'h0003, 1'b1);
        send_request(tlbol_pkg::KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(tlbol_pkg::KIND_LOOKUP, 16'h0003, 16'h0003, 16'h0000, 1'b0);
        items_sent = 21;

        for (p = 0; p < 9; p++)
        begin
            wait_drained();
            program_entries(5'(phase_entries[p]));
            run_random_items(ITEMS_PER_PHASE, p == 3);
            phases_run++;
        end

        wait_drained();
        repeat (TLB_SLOTS + 4)
            @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.fail_count++;
        end
        $display("checked %0d transactions over %0d register settings plus a directed set,",
                 sb.checked, phases_run);
        $display("with %0d lookup hits and %0d dirty write-backs", sb.hits, sb.writebacks);
        if (sb.fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
